// ===== hw/rtl/iiee_pkg.sv =====
// ============================================================================
// iiee_pkg
// Shared types and constants for the left-to-right integer expression
// evaluator: character codes, status codes and the arithmetic unit handshake.
// ============================================================================
`default_nettype none

package iiee_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int CHAR_W          = 8;
  localparam int VALUE_OUT_W     = 32;
  localparam int STATUS_W        = 3;

  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EXPECT_NUM = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ENDS_OP    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DIV_ZERO   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_BAD_OP     = 3'd5;

  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_SUB = 2'd1,
    ALU_MUL = 2'd2,
    ALU_DIV = 2'd3
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/iiee_if.sv =====
// ============================================================================
// iiee_if
// Valid/ready channels: text characters in, evaluated results out.
// ============================================================================
`default_nettype none

interface iiee_char_if;
  import iiee_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              end_of_line;

  modport source (output valid, character, end_of_line, input ready);
  modport sink   (input valid, character, end_of_line, output ready);
endinterface

interface iiee_res_if;
  import iiee_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [VALUE_OUT_W-1:0] value;
  logic [STATUS_W-1:0]           status;

  modport source (output valid, value, status, input ready);
  modport sink   (input valid, value, status, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/iiee_alu.sv =====
// ============================================================================
// iiee_alu
// Iterative arithmetic unit built round one shared adder: add and subtract
// in one step, shift-add multiply and restoring signed divide one bit a step.
// ============================================================================
`default_nettype none

module iiee_alu #(
  parameter int VALUE_WIDTH = iiee_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire iiee_pkg::alu_ctl_t     ctl,
  input  wire logic [VALUE_WIDTH-1:0] a,
  input  wire logic [VALUE_WIDTH-1:0] b,
  output logic                        done,
  output logic [VALUE_WIDTH-1:0]      res
);
  import iiee_pkg::*;

  localparam int VW = VALUE_WIDTH;
  localparam int CW = $clog2(VW);
  localparam logic [CW-1:0] CNT_LAST = CW'(VW - 1);

  typedef enum logic [6:0] {
    U_IDLE = 7'b0000001,
    U_ADD  = 7'b0000010,
    U_MUL  = 7'b0000100,
    U_NEGA = 7'b0001000,
    U_NEGB = 7'b0010000,
    U_DIV  = 7'b0100000,
    U_FIX  = 7'b1000000
  } ustate_t;

  ustate_t       state;
  logic [VW-1:0] ra;
  logic [VW-1:0] rb;
  logic [VW-1:0] rq;
  logic [CW-1:0] cnt;
  logic          sub;
  logic          negq;

  logic [VW:0] add_x;
  logic [VW:0] add_y;
  logic        add_cin;
  logic [VW:0] sum;

  // shared adder operand selection
  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_cin = 1'b0;
    case (state)
      U_ADD: begin
        add_x   = {1'b0, ra};
        add_y   = sub ? ~{1'b0, rb} : {1'b0, rb};
        add_cin = sub;
      end
      U_MUL: begin
        add_x = {1'b0, ra};
        add_y = {1'b0, rb};
      end
      U_NEGA: begin
        add_y   = ~{1'b0, ra};
        add_cin = 1'b1;
      end
      U_NEGB: begin
        add_y   = ~{1'b0, rb};
        add_cin = 1'b1;
      end
      U_DIV: begin
        add_x   = {ra, rq[VW-1]};
        add_y   = ~{1'b0, rb};
        add_cin = 1'b1;
      end
      U_FIX: begin
        add_y   = ~{1'b0, rq};
        add_cin = 1'b1;
      end
      default: begin
        add_x = '0;
      end
    endcase
    sum = add_x + add_y + (VW+1)'(add_cin);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
      done  <= 1'b0;
    end else begin
      case (state)
        U_IDLE: begin
          done <= 1'b0;
          if (ctl.start) begin
            sub  <= (ctl.op == ALU_SUB);
            negq <= a[VW-1] ^ b[VW-1];
            cnt  <= '0;
            case (ctl.op)
              ALU_MUL: begin
                ra    <= '0;
                rb    <= a;
                rq    <= b;
                state <= U_MUL;
              end
              ALU_DIV: begin
                ra    <= a;
                rb    <= b;
                state <= U_NEGA;
              end
              default: begin
                ra    <= a;
                rb    <= b;
                state <= U_ADD;
              end
            endcase
          end
        end
        U_ADD: begin
          res   <= sum[VW-1:0];
          done  <= 1'b1;
          state <= U_IDLE;
        end
        U_MUL: begin
          if (rq[0]) begin
            ra <= sum[VW-1:0];
          end
          rb   <= rb << 1;
          rq   <= rq >> 1;
          cnt  <= cnt + 1'b1;
          done <= (cnt == CNT_LAST);
          if (cnt == CNT_LAST) begin
            res   <= rq[0] ? sum[VW-1:0] : ra;
            state <= U_IDLE;
          end
        end
        U_NEGA: begin
          done <= 1'b0;
          if (ra[VW-1]) begin
            ra <= sum[VW-1:0];
          end
          state <= U_NEGB;
        end
        U_NEGB: begin
          done <= 1'b0;
          if (rb[VW-1]) begin
            rb <= sum[VW-1:0];
          end
          rq    <= ra;
          ra    <= '0;
          state <= U_DIV;
        end
        U_DIV: begin
          done <= 1'b0;
          // no borrow: the trial subtraction stands
          ra  <= sum[VW] ? {ra[VW-2:0], rq[VW-1]} : sum[VW-1:0];
          rq  <= {rq[VW-2:0], ~sum[VW]};
          cnt <= cnt + 1'b1;
          if (cnt == CNT_LAST) begin
            state <= U_FIX;
          end
        end
        U_FIX: begin
          res   <= negq ? sum[VW-1:0] : rq;
          done  <= 1'b1;
          state <= U_IDLE;
        end
        default: begin
          done  <= 1'b0;
          state <= U_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/infix_integer_expression_evaluator.sv =====
// ============================================================================
// infix_integer_expression_evaluator
// Character-serial parser and sequencer for left-to-right + - * / integer
// expressions, with one iterative arithmetic unit and a registered result.
// ============================================================================
//
//   channel  | dir | beat fields               | notes
//   ---------+-----+---------------------------+------------------------------
//   text     | in  | character, end_of_line    | one byte of the line per beat
//   result   | out | value, status             | one beat per end-of-line mark
//
// Digits, spaces and parse errors are taken in S_IDLE; an end-of-line beat
// leads on to S_EMIT for the result. A fold waits in S_FOLD for iiee_alu,
// whose shared adder steps one bit a cycle for * and /. text.ready is low
// while a fold runs or a finished result waits for the output register to
// empty.
// Synchronous reset clears the parser and drops any result not yet taken.
//
`default_nettype none

module infix_integer_expression_evaluator #(
  parameter int VALUE_WIDTH = iiee_pkg::VALUE_WIDTH_DEF
) (
  input wire logic clk,
  input wire logic rst,
  iiee_char_if.sink  text,
  iiee_res_if.source result
);
  import iiee_pkg::*;

  localparam int VW = VALUE_WIDTH;

  typedef enum logic [2:0] {
    PH_FIRST    = 3'b001,
    PH_NUMBER   = 3'b010,
    PH_AFTER_OP = 3'b100
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_FOLD = 3'b010,
    S_EMIT = 3'b100
  } seq_t;

  seq_t                state;
  phase_t              phase;
  logic [VW-1:0]       acc;
  logic [VW-1:0]       running;
  logic [CHAR_W-1:0]   pending;
  logic                have_first;
  logic [STATUS_W-1:0] perr;
  logic [STATUS_W-1:0] eerr;
  logic                final_line;

  logic                accept;
  logic                is_digit;
  logic                active;
  logic [VW-1:0]       digit;
  logic [VW-1:0]       acc_x10;
  logic [VW-1:0]       acc_next;
  phase_t              phase_next;
  logic [STATUS_W-1:0] perr_next;
  logic [STATUS_W-1:0] eerr_next;
  logic                do_fold;
  logic                alu_start;
  alu_op_t             alu_op;

  alu_ctl_t            alu_ctl;
  logic                alu_done;
  logic [VW-1:0]       alu_res;

  logic                       emit;
  logic [STATUS_W-1:0]        status_next;
  logic [VW+VALUE_OUT_W-1:0]  value_ext;

  assign text.ready = (state == S_IDLE);
  assign accept     = text.valid && text.ready;

  always_comb begin
    is_digit   = text.character inside {[CH_ZERO:CH_NINE]};
    active     = (perr == ST_OK) && (text.character != CH_SPACE);
    digit      = VW'(text.character[3:0]);
    acc_x10    = (acc << 3) + (acc << 1) + digit;
    acc_next   = acc;
    phase_next = phase;
    perr_next  = perr;
    eerr_next  = eerr;
    do_fold    = 1'b0;
    alu_start  = 1'b0;
    alu_op     = ALU_ADD;

    if (active) begin
      if (is_digit) begin
        acc_next   = (phase == PH_NUMBER) ? acc_x10 : digit;
        phase_next = PH_NUMBER;
      end else if (phase == PH_NUMBER) begin
        do_fold    = 1'b1;
        phase_next = PH_AFTER_OP;
      end else begin
        perr_next = ST_EXPECT_NUM;
      end
    end

    if (text.end_of_line && perr_next == ST_OK) begin
      case (phase_next)
        PH_FIRST:    perr_next = ST_EMPTY;
        PH_AFTER_OP: perr_next = ST_ENDS_OP;
        default:     do_fold = 1'b1;
      endcase
    end

    // fold against the operator left of this number
    if (do_fold && have_first && eerr == ST_OK) begin
      case (pending)
        CH_PLUS: begin
          alu_start = 1'b1;
          alu_op    = ALU_ADD;
        end
        CH_MINUS: begin
          alu_start = 1'b1;
          alu_op    = ALU_SUB;
        end
        CH_STAR: begin
          alu_start = 1'b1;
          alu_op    = ALU_MUL;
        end
        CH_SLASH: begin
          if (acc_next == '0) begin
            eerr_next = ST_DIV_ZERO;
          end else begin
            alu_start = 1'b1;
            alu_op    = ALU_DIV;
          end
        end
        default: begin
          eerr_next = ST_BAD_OP;
        end
      endcase
    end
  end

  assign alu_ctl.start = accept && alu_start;
  assign alu_ctl.op    = alu_op;

  iiee_alu #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_alu (
    .clk  (clk),
    .rst  (rst),
    .ctl  (alu_ctl),
    .a    (running),
    .b    (acc_next),
    .done (alu_done),
    .res  (alu_res)
  );

  assign emit = (state == S_EMIT) && (!result.valid || result.ready);

  always_comb begin
    if (perr != ST_OK) begin
      status_next = perr;
    end else begin
      status_next = eerr;
    end
    value_ext = {{VALUE_OUT_W{1'b0}}, running};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      phase        <= PH_FIRST;
      acc          <= '0;
      running      <= '0;
      pending      <= '0;
      have_first   <= 1'b0;
      perr         <= ST_OK;
      eerr         <= ST_OK;
      final_line   <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (emit) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            acc        <= acc_next;
            phase      <= phase_next;
            perr       <= perr_next;
            eerr       <= eerr_next;
            final_line <= text.end_of_line;
            if (active && !is_digit && phase == PH_NUMBER) begin
              pending <= text.character;
            end
            if (do_fold && !have_first) begin
              running    <= acc_next;
              have_first <= 1'b1;
            end
            if (alu_start) begin
              state <= S_FOLD;
            end else if (text.end_of_line) begin
              state <= S_EMIT;
            end
          end
        end
        S_FOLD: begin
          if (alu_done) begin
            running <= alu_res;
            state   <= final_line ? S_EMIT : S_IDLE;
          end
        end
        S_EMIT: begin
          if (emit) begin
            result.status <= status_next;
            result.value  <= (status_next == ST_OK) ? value_ext[VALUE_OUT_W-1:0] : '0;
            phase         <= PH_FIRST;
            acc           <= '0;
            running       <= '0;
            pending       <= '0;
            have_first    <= 1'b0;
            perr          <= ST_OK;
            eerr          <= ST_OK;
            final_line    <= 1'b0;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== tb/infix_integer_expression_evaluator_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// infix_integer_expression_evaluator_tb
// Drives expression text one character per beat and checks each end-of-line
// result against a left-to-right evaluator kept in a small scoreboard class.
// A directed set of lines comes first, then random well-formed, broken and
// noise lines, with random idling on both channels and one long result stall.
// ============================================================================

module infix_integer_expression_evaluator_tb;
  import iiee_pkg::*;

  localparam int NUM_CHARS     = 2000;
  localparam int CALM_FROM     = 1800;
  localparam int HOLD_CYCLES   = 400;
  localparam int HOLD_AFTER    = 30;
  localparam int DRAIN_CYCLES  = 48;
  localparam int WATCHDOG_MAX  = 2000;

  typedef enum logic [1:0] {
    WANT_FIRST,
    IN_NUMBER,
    WANT_OPERAND
  } parse_phase_t;

  typedef struct packed {
    logic signed [VALUE_OUT_W-1:0] value;
    logic [STATUS_W-1:0]           status;
  } eval_result_t;

  class eval_scoreboard;
    parse_phase_t          phase;
    logic [31:0]           number;
    logic [31:0]           total;
    logic [CHAR_W-1:0]     pending_op;
    bit                    have_first;
    logic [STATUS_W-1:0]   parse_err;
    logic [STATUS_W-1:0]   eval_err;
    eval_result_t          pending_results[$];
    int                    errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      phase      = WANT_FIRST;
      number     = '0;
      total      = '0;
      pending_op = '0;
      have_first = 1'b0;
      parse_err  = ST_OK;
      eval_err   = ST_OK;
    endfunction

    function void fold();
      logic [31:0] mag_a;
      logic [31:0] mag_b;
      logic [31:0] quo;
      if (!have_first) begin
        total      = number;
        have_first = 1'b1;
        return;
      end
      if (eval_err != ST_OK) return;
      case (pending_op)
        CH_PLUS:  total = total + number;
        CH_MINUS: total = total - number;
        CH_STAR:  total = total * number;
        CH_SLASH: begin
          if (number == '0) begin
            eval_err = ST_DIV_ZERO;
          end else begin
            mag_a = total[31] ? -total : total;
            mag_b = number[31] ? -number : number;
            quo   = mag_a / mag_b;
            total = (total[31] ^ number[31]) ? -quo : quo;
          end
        end
        default:  eval_err = ST_BAD_OP;
      endcase
    endfunction

    function void take_char(logic [CHAR_W-1:0] c, bit eol);
      eval_result_t res;
      if (parse_err == ST_OK && c != CH_SPACE) begin
        if (c >= CH_ZERO && c <= CH_NINE) begin
          if (phase == IN_NUMBER) number = number * 32'd10 + 32'(c - CH_ZERO);
          else number = 32'(c - CH_ZERO);
          phase = IN_NUMBER;
        end else if (phase == IN_NUMBER) begin
          fold();
          pending_op = c;
          phase      = WANT_OPERAND;
        end else begin
          parse_err = ST_EXPECT_NUM;
        end
      end
      if (!eol) return;
      if (parse_err == ST_OK) begin
        if (phase == WANT_FIRST) parse_err = ST_EMPTY;
        else if (phase == WANT_OPERAND) parse_err = ST_ENDS_OP;
        else fold();
      end
      res.value = '0;
      if (parse_err != ST_OK) begin
        res.status = parse_err;
      end else if (eval_err != ST_OK) begin
        res.status = eval_err;
      end else begin
        res.status = ST_OK;
        res.value  = total;
      end
      pending_results.push_back(res);
      clear();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 100) $display("mismatch: %s", msg);
    endtask

    task check_result(logic signed [VALUE_OUT_W-1:0] value, logic [STATUS_W-1:0] status);
      eval_result_t exp_r;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected beat value=%0d status=%0d", value, status));
        return;
      end
      exp_r = pending_results.pop_front();
      if (status !== exp_r.status)
        report($sformatf("status %0d, want %0d", status, exp_r.status));
      if (value !== exp_r.value)
        report($sformatf("value %0d, want %0d", value, exp_r.value));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;

  iiee_char_if text_ch();
  iiee_res_if  res_ch();

  infix_integer_expression_evaluator u_top (
    .clk    (clk),
    .rst    (rst),
    .text   (text_ch),
    .result (res_ch)
  );

  eval_scoreboard    expr_sb = new();
  logic [CHAR_W-1:0] line[$];
  bit                idle_on = 1'b1;
  int                chars_sent = 0;
  int                results_seen = 0;
  int                quiet_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic send_char(input logic [CHAR_W-1:0] c, input bit eol);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      text_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    text_ch.valid       <= 1'b1;
    text_ch.character   <= c;
    text_ch.end_of_line <= eol;
    do @(posedge clk); while (!text_ch.ready);
    expr_sb.take_char(c, eol);
    chars_sent++;
  endtask

  task automatic send_line();
    for (int i = 0; i < line.size(); i++) send_char(line[i], i == line.size() - 1);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) line.push_back(s[i]);
  endtask

  task automatic put_number();
    int r;
    int len;
    r = $urandom_range(0, 99);
    if (r < 10) len = 1;
    else if (r < 70) len = $urandom_range(1, 2);
    else if (r < 90) len = $urandom_range(3, 5);
    else len = $urandom_range(6, 12);
    for (int i = 0; i < len; i++)
      line.push_back(CHAR_W'(CH_ZERO + ((r < 10) ? 0 : $urandom_range(0, 9))));
  endtask

  task automatic put_operator();
    logic [CHAR_W-1:0] c;
    case ($urandom_range(0, 19))
      0, 1, 2, 3: c = CH_PLUS;
      4, 5, 6, 7: c = CH_MINUS;
      8, 9, 10, 11: c = CH_STAR;
      12, 13, 14, 15, 16: c = CH_SLASH;
      default: begin
        do c = CHAR_W'($urandom_range(0, 255));
        while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_SPACE);
      end
    endcase
    line.push_back(c);
  endtask

  task automatic put_spaces();
    if ($urandom_range(0, 6) == 0)
      repeat ($urandom_range(1, 2)) line.push_back(CH_SPACE);
  endtask

  task automatic build_line();
    int kind;
    int operands;
    line = {};
    kind = $urandom_range(0, 99);
    if (kind >= 85) begin
      repeat ($urandom_range(1, 12)) line.push_back(CHAR_W'($urandom_range(0, 255)));
      return;
    end
    operands = $urandom_range(1, 6);
    put_spaces();
    for (int i = 0; i < operands; i++) begin
      if (i > 0) begin
        put_operator();
        put_spaces();
      end
      put_number();
      put_spaces();
    end
    if (kind >= 70) begin
      case ($urandom_range(0, 3))
        0: put_operator();
        1: begin
          put_operator();
          put_operator();
          put_number();
        end
        2: line.push_front(CH_STAR);
        default: begin
          line = {};
          repeat ($urandom_range(1, 3)) line.push_back(CH_SPACE);
        end
      endcase
    end
  endtask

  // result side: random stalls, plus one long hold-off to back up the input
  initial begin
    bit held;
    int stall_left;
    held       = 1'b0;
    stall_left = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid && res_ch.ready) begin
        expr_sb.check_result(res_ch.value, res_ch.status);
        results_seen++;
      end
      if (!held && results_seen >= HOLD_AFTER) begin
        held = 1'b1;
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 11) - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((text_ch.valid && text_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("timeout: no beat for %0d cycles", WATCHDOG_MAX);
      $display("[infix_integer_expression_evaluator] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int line_no;
    line_no = 0;
    rst                 <= 1'b1;
    text_ch.valid       <= 1'b0;
    text_ch.character   <= '0;
    text_ch.end_of_line <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed lines
    line = {CH_SPACE};
    send_line();
    line = {CH_STAR};
    send_line();
    line = {};
    put_text("1/0+");
    send_line();
    line = {};
    put_text("8/0+5");
    send_line();
    line = {};
    put_text("5");
    line.push_back(8'hFF);
    put_text("3/0");
    send_line();
    line = {};
    put_text("4");
    line.push_back(8'h00);
    put_text("2");
    send_line();
    line = {};
    put_text("2147483648/4294967295");
    send_line();

    // random lines
    while (chars_sent < NUM_CHARS) begin
      if (chars_sent >= CALM_FROM) idle_on = 1'b0;
      else if (line_no % 16 == 0) idle_on = ($urandom_range(0, 3) != 0);
      build_line();
      send_line();
      line_no++;
    end
    idle_on = 1'b0;

    @(posedge clk);
    text_ch.valid <= 1'b0;
    while (expr_sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expr_sb.errors == 0) begin
      $display("[infix_integer_expression_evaluator] OK");
    end else begin
      $display("[infix_integer_expression_evaluator] ERROR");
    end
    $finish;
  end

endmodule
